// ===== sv/swhs_pkg.sv =====
// ----------------------------------------------------------------------------
// swhs_pkg
// Shared types and constants of the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package swhs_pkg;

  // field and register widths
  localparam int TYPE_W     = 3;
  localparam int TICK_REG_W = 20;
  localparam int STATUS_W   = 2;
  localparam int VALUE_W    = 16;
  localparam int FRAME_W    = 40;
  localparam int PIDX_W     = 6;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // pulse pair counts of one frame
  localparam logic [PIDX_W-1:0] PAIRS_TOTAL   = 6'd42;
  localparam logic [PIDX_W-1:0] PAIRS_SKIPPED = 6'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_SENSOR_TYPE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRE_HIGH    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_LOW   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT     = 3'd4;

  // register reset values
  localparam logic [TYPE_W-1:0]     RST_SENSOR_TYPE = 3'd2;
  localparam logic [TICK_REG_W-1:0] RST_PRE_HIGH    = 20'd250000;
  localparam logic [TICK_REG_W-1:0] RST_START_LOW   = 20'd20000;
  localparam logic [TICK_REG_W-1:0] RST_RELEASE     = 20'd50;
  localparam logic [TICK_REG_W-1:0] RST_TIMEOUT     = 20'd100000;

  // sensor type codes
  localparam logic [TYPE_W-1:0] TYPE_BYTE     = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_TENTHS_A = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_TENTHS_B = 3'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE_HIGH,
    PH_START_LOW,
    PH_RELEASE,
    PH_LISTEN_HIGH,
    PH_LISTEN_LOW
  } phase_t;

  // configuration register set
  typedef struct packed {
    logic [TYPE_W-1:0]     sensor_type;
    logic [TICK_REG_W-1:0] pre_high_ticks;
    logic [TICK_REG_W-1:0] start_low_ticks;
    logic [TICK_REG_W-1:0] release_ticks;
    logic [TICK_REG_W-1:0] timeout_ticks;
  } cfg_t;

  // end-of-read event from the sequencer
  typedef struct packed {
    logic               finish;
    logic               timeout;
    logic [FRAME_W-1:0] frame;
  } seq_event_t;

  // one result item
  typedef struct packed {
    logic                drive_low;
    logic                drive_enable;
    logic                busy_res;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  humidity_tenths;
    logic [VALUE_W-1:0]  temperature_tenths;
  } result_t;

endpackage

// ===== sv/swhs_in_if.sv =====
// ----------------------------------------------------------------------------
// swhs_in_if
// Input channel: start request and line sample, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swhs_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic line_level;

  modport source (output valid, output start_request, output line_level, input ready);
  modport sink   (input valid, input start_request, input line_level, output ready);
endinterface

// ===== sv/swhs_out_if.sv =====
// ----------------------------------------------------------------------------
// swhs_out_if
// Result channel: line drive, read status and decoded values.
// ----------------------------------------------------------------------------
interface swhs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          drive_low;
  logic                          drive_enable;
  logic                          busy_res;
  logic                          done_res;
  logic [swhs_pkg::STATUS_W-1:0] status;
  logic [swhs_pkg::VALUE_W-1:0]  humidity_tenths;
  logic [swhs_pkg::VALUE_W-1:0]  temperature_tenths;

  modport source (
    output valid, output drive_low, output drive_enable, output busy_res,
    output done_res, output status, output humidity_tenths,
    output temperature_tenths, input ready
  );
  modport sink (
    input valid, input drive_low, input drive_enable, input busy_res,
    input done_res, input status, input humidity_tenths,
    input temperature_tenths, output ready
  );
endinterface

// ===== sv/swhs_seq.sv =====
// ----------------------------------------------------------------------------
// swhs_seq
// Read sequencer: drive phases, pulse timing, budget and frame capture.
// ----------------------------------------------------------------------------
module swhs_seq #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 start_request,
  input  logic                 line_level,
  input  swhs_pkg::cfg_t       cfg,
  output swhs_pkg::phase_t     phase_nxt,
  output swhs_pkg::seq_event_t ev
);
  import swhs_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > TICK_REG_W) ? COUNT_WIDTH : TICK_REG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  phase_t                 phase_r;
  logic [COUNT_WIDTH-1:0] phase_ticks_r, phase_ticks_nxt;
  logic [COUNT_WIDTH-1:0] budget_r, budget_nxt;
  logic [COUNT_WIDTH-1:0] high_r, high_nxt;
  logic [COUNT_WIDTH-1:0] low_r, low_nxt;
  logic [PIDX_W-1:0]      pidx_r, pidx_nxt;
  logic [FRAME_W-1:0]     frame_r, frame_nxt;

  logic [TICK_REG_W-1:0]  drive_len;
  logic [COUNT_WIDTH-1:0] ticks_inc, high_inc, low_inc;
  logic [PIDX_W-1:0]      pidx_inc;
  logic                   drive_end;
  logic                   pair_bit;

  // clip a register value to the counter range
  function automatic logic [COUNT_WIDTH-1:0] clip(input logic [TICK_REG_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (ve > CMP_W'(CNT_MAX)) clip = CNT_MAX;
    else                      clip = COUNT_WIDTH'(ve);
  endfunction

  // length of the current drive phase
  always_comb begin
    case (phase_r)
      PH_PRE_HIGH:  drive_len = cfg.pre_high_ticks;
      PH_START_LOW: drive_len = cfg.start_low_ticks;
      default:      drive_len = cfg.release_ticks;
    endcase
  end

  // saturating counters and pair decision
  assign ticks_inc = (phase_ticks_r == CNT_MAX) ? CNT_MAX : phase_ticks_r + 1'b1;
  assign high_inc  = (high_r == CNT_MAX) ? CNT_MAX : high_r + 1'b1;
  assign low_inc   = (low_r == CNT_MAX) ? CNT_MAX : low_r + 1'b1;
  assign drive_end = (ticks_inc >= clip(drive_len));
  assign pidx_inc  = pidx_r + 1'b1;
  assign pair_bit  = (high_r > low_inc);

  // next state of the read
  always_comb begin
    phase_nxt       = phase_r;
    phase_ticks_nxt = phase_ticks_r;
    budget_nxt      = budget_r;
    high_nxt        = high_r;
    low_nxt         = low_r;
    pidx_nxt        = pidx_r;
    frame_nxt       = frame_r;
    ev.finish       = 1'b0;
    ev.timeout      = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (start_request) begin
          phase_nxt       = PH_PRE_HIGH;
          phase_ticks_nxt = '0;
        end
      end
      PH_PRE_HIGH, PH_START_LOW, PH_RELEASE: begin
        phase_ticks_nxt = ticks_inc;
        if (drive_end) begin
          phase_ticks_nxt = '0;
          case (phase_r)
            PH_PRE_HIGH:  phase_nxt = PH_START_LOW;
            PH_START_LOW: phase_nxt = PH_RELEASE;
            default: begin
              phase_nxt  = PH_LISTEN_HIGH;
              budget_nxt = clip(cfg.timeout_ticks);
              high_nxt   = '0;
              low_nxt    = '0;
              pidx_nxt   = '0;
              frame_nxt  = '0;
            end
          endcase
        end
      end
      PH_LISTEN_HIGH, PH_LISTEN_LOW: begin
        if (budget_r == '0) begin
          ev.timeout = 1'b1;
          phase_nxt  = PH_IDLE;
        end else begin
          budget_nxt = budget_r - 1'b1;
          if (phase_r == PH_LISTEN_HIGH) begin
            high_nxt = high_inc;
            if (!line_level) phase_nxt = PH_LISTEN_LOW;
          end else begin
            low_nxt = low_inc;
            if (line_level) begin
              pidx_nxt = pidx_inc;
              if (pidx_inc > PAIRS_SKIPPED) frame_nxt = {frame_r[FRAME_W-2:0], pair_bit};
              high_nxt  = '0;
              low_nxt   = '0;
              phase_nxt = PH_LISTEN_HIGH;
              if (pidx_inc >= PAIRS_TOTAL) begin
                ev.finish = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
    ev.frame = frame_nxt;
  end

  // state registers, advanced once per accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      phase_ticks_r <= '0;
      budget_r      <= '0;
      high_r        <= '0;
      low_r         <= '0;
      pidx_r        <= '0;
      frame_r       <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      phase_ticks_r <= phase_ticks_nxt;
      budget_r      <= budget_nxt;
      high_r        <= high_nxt;
      low_r         <= low_nxt;
      pidx_r        <= pidx_nxt;
      frame_r       <= frame_nxt;
    end
  end

endmodule

// ===== sv/swhs_decode.sv =====
// ----------------------------------------------------------------------------
// swhs_decode
// Frame check and value conversion, plus line drive from the next phase.
// ----------------------------------------------------------------------------
module swhs_decode (
  input  logic [swhs_pkg::TYPE_W-1:0] sensor_type,
  input  swhs_pkg::phase_t            phase_nxt,
  input  swhs_pkg::seq_event_t        ev,
  output swhs_pkg::result_t           res
);
  import swhs_pkg::*;

  logic [7:0]         b0, b1, b2, b3, b4, sum;
  logic [VALUE_W-1:0] hum, temp;
  logic [STATUS_W-1:0] st;

  // bytes of the frame, first received byte highest
  assign b0  = ev.frame[39:32];
  assign b1  = ev.frame[31:24];
  assign b2  = ev.frame[23:16];
  assign b3  = ev.frame[15:8];
  assign b4  = ev.frame[7:0];
  assign sum = b0 + b1 + b2 + b3;

  // value conversion and status by sensor type
  always_comb begin
    hum  = '0;
    temp = '0;
    st   = ST_OK;
    case (sensor_type) inside
      TYPE_BYTE: begin
        hum  = (VALUE_W'(b0) << 3) + (VALUE_W'(b0) << 1);
        temp = (VALUE_W'(b2) << 3) + (VALUE_W'(b2) << 1);
        st   = (sum != b4) ? ST_CHECKSUM : ST_OK;
      end
      TYPE_TENTHS_A, TYPE_TENTHS_B: begin
        hum  = {b0, b1};
        temp = {b2, b3};
        st   = (sum != b4) ? ST_CHECKSUM : ST_OK;
      end
      default: st = ST_UNKNOWN;
    endcase
  end

  // result item
  always_comb begin
    res.drive_low          = (phase_nxt == PH_START_LOW);
    res.drive_enable       = (phase_nxt == PH_PRE_HIGH) || (phase_nxt == PH_START_LOW) ||
                             (phase_nxt == PH_RELEASE);
    res.busy_res           = (phase_nxt != PH_IDLE);
    res.done_res           = ev.finish || ev.timeout;
    res.status             = ST_OK;
    res.humidity_tenths    = '0;
    res.temperature_tenths = '0;
    if (ev.timeout) begin
      res.status = ST_TIMEOUT;
    end else if (ev.finish) begin
      res.status             = st;
      res.humidity_tenths    = hum;
      res.temperature_tenths = temp;
    end
  end

endmodule

// ===== sv/single_wire_humidity_sensor_reader_core.sv =====
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_core
// Single-wire humidity sensor reader with register port and result register.
// ----------------------------------------------------------------------------
// the result of a sample is registered and on the output in the cycle after its transfer
// throughput: one sample per cycle while the output is not stalled, set by the single state update per tick
// a whole read spans pre_high + start_low + release ticks plus the frame
// synchronous reset clears the sequencer to idle and the output valid flag;
// registers return to their defaults
module single_wire_humidity_sensor_reader_core #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  swhs_in_if.sink                         in_ch,
  swhs_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [swhs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [swhs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [swhs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import swhs_pkg::*;

  cfg_t              cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic              cfg_wr;
  logic              accept;
  logic              out_valid_r, out_valid_nxt;
  result_t           res, res_r;
  phase_t            phase_nxt;
  seq_event_t        ev;

  // register port
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_type     <= RST_SENSOR_TYPE;
      cfg_r.pre_high_ticks  <= RST_PRE_HIGH;
      cfg_r.start_low_ticks <= RST_START_LOW;
      cfg_r.release_ticks   <= RST_RELEASE;
      cfg_r.timeout_ticks   <= RST_TIMEOUT;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SENSOR_TYPE: cfg_r.sensor_type     <= cfg_pwdata[TYPE_W-1:0];
        REG_PRE_HIGH:    cfg_r.pre_high_ticks  <= cfg_pwdata[TICK_REG_W-1:0];
        REG_START_LOW:   cfg_r.start_low_ticks <= cfg_pwdata[TICK_REG_W-1:0];
        REG_RELEASE:     cfg_r.release_ticks   <= cfg_pwdata[TICK_REG_W-1:0];
        REG_TIMEOUT:     cfg_r.timeout_ticks   <= cfg_pwdata[TICK_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_SENSOR_TYPE: cfg_prdata = CFG_DATA_W'(cfg_r.sensor_type);
      REG_PRE_HIGH:    cfg_prdata = CFG_DATA_W'(cfg_r.pre_high_ticks);
      REG_START_LOW:   cfg_prdata = CFG_DATA_W'(cfg_r.start_low_ticks);
      REG_RELEASE:     cfg_prdata = CFG_DATA_W'(cfg_r.release_ticks);
      REG_TIMEOUT:     cfg_prdata = CFG_DATA_W'(cfg_r.timeout_ticks);
      default:         cfg_prdata = '0;
    endcase
  end

  // input transfer whenever the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  swhs_seq #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (accept),
    .start_request(in_ch.start_request),
    .line_level   (in_ch.line_level),
    .cfg          (cfg_r),
    .phase_nxt    (phase_nxt),
    .ev           (ev)
  );

  swhs_decode u_decode (
    .sensor_type(cfg_r.sensor_type),
    .phase_nxt  (phase_nxt),
    .ev         (ev),
    .res        (res)
  );

  // output register
  always_comb begin
    if (accept)            out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= res;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.drive_low          = res_r.drive_low;
  assign out_ch.drive_enable       = res_r.drive_enable;
  assign out_ch.busy_res           = res_r.busy_res;
  assign out_ch.done_res           = res_r.done_res;
  assign out_ch.status             = res_r.status;
  assign out_ch.humidity_tenths    = res_r.humidity_tenths;
  assign out_ch.temperature_tenths = res_r.temperature_tenths;

endmodule

// ===== sv/swhs_checker.sv =====
// ----------------------------------------------------------------------------
// swhs_checker
// Port-level checks of the reader core, attached by bind.
// ----------------------------------------------------------------------------
module swhs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          drive_low,
  input logic                          drive_enable,
  input logic                          busy_res,
  input logic                          done_res,
  input logic [swhs_pkg::STATUS_W-1:0] status,
  input logic [swhs_pkg::VALUE_W-1:0]  humidity_tenths
);
  import swhs_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(humidity_tenths))
    else $error("stalled result changed");

  // a finished read is no longer busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res && !drive_enable)
    else $error("done while still busy");

  // status and values only on the finishing transfer
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !done_res |-> status == ST_OK && humidity_tenths == '0)
    else $error("status or value outside a finished read");

  // pulling low is always a drive and part of a read
  a_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && drive_low |-> drive_enable && busy_res)
    else $error("low drive outside start pulse");

endmodule

bind single_wire_humidity_sensor_reader_core swhs_checker u_swhs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .drive_low      (out_ch.drive_low),
  .drive_enable   (out_ch.drive_enable),
  .busy_res       (out_ch.busy_res),
  .done_res       (out_ch.done_res),
  .status         (out_ch.status),
  .humidity_tenths(out_ch.humidity_tenths)
);
